### src/bsp_pkg.sv
package bsp_pkg;

    localparam int CW  = 25;    // corner coordinate, signed Q16.8
    localparam int KW  = 16;    // matrix coefficient, signed Q1.14
    localparam int PW  = 41;    // coefficient times corner
    localparam int TW  = 43;    // rotated component, 22 fraction bits
    localparam int PSW = 20;    // pixel scale
    localparam int CRW = 13;    // centre and screen size
    localparam int OW  = 17;    // pixel coordinate
    localparam int RW  = 48;    // register data width
    localparam int QB  = 18;    // quotient bits below the saturation point
    localparam int NW  = 65;    // rounded dividend
    localparam int DW  = 48;    // doubled divisor
    localparam int MW  = 64;    // product magnitude
    localparam int XW  = 67;    // divider remainder
    localparam int AXIS_LAT = QB + 5;

    localparam logic signed [OW-1:0] EDGE_MARGIN = 17'sd2;
    localparam logic signed [OW-1:0] COORD_MAX   = 17'sd65535;
    localparam logic signed [OW-1:0] COORD_MIN   = -17'sd65536;

    typedef enum logic [2:0] {
        CFG_ROT0     = 3'd0,
        CFG_ROT1     = 3'd1,
        CFG_ROT2     = 3'd2,
        CFG_SCALE    = 3'd3,
        CFG_CENTRE_X = 3'd4,
        CFG_CENTRE_Y = 3'd5,
        CFG_WIDTH    = 3'd6,
        CFG_HEIGHT   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [PSW-1:0] scale;
        logic [CRW-1:0] centre;
    } t_axis_cfg;

endpackage

### src/bsp_box_if.sv
interface bsp_box_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] center_z;
    logic [22:0]        half_x;
    logic [22:0]        half_y;
    logic [22:0]        half_z;

    modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
                    input ready);
    modport sink (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
                  output ready);
endinterface

### src/bsp_rect_if.sv
interface bsp_rect_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic signed [16:0] bottom;
    logic signed [16:0] top;
    logic               behind_camera;

    modport source (output valid, left, right, bottom, top, behind_camera, input ready);
    modport sink (input valid, left, right, bottom, top, behind_camera, output ready);
endinterface

### src/bsp_axis.sv
module bsp_axis import bsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_axis_cfg             i_cfg,
    input  logic signed [TW-1:0]  i_t,
    input  logic signed [TW-1:0]  i_tz,
    output logic signed [OW-1:0]  o_p
);

    // stage 0: split product, divisor
    logic [41:0]        r0_lo;
    logic signed [41:0] r0_hi;
    logic [DW-1:0]      r0_den;
    logic               r0_beh;
    logic [CRW-1:0]     r0_cen;
    logic [TW:0]        n0_negz;

    assign n0_negz = -{i_tz[TW-1], i_tz};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_lo  <= i_t[21:0] * i_cfg.scale;
            r0_hi  <= $signed(i_t[TW-1:22]) * $signed({1'b0, i_cfg.scale});
            r0_den <= {n0_negz[DW-5:0], 4'b0};
            r0_beh <= ~i_tz[TW-1];
            r0_cen <= i_cfg.centre;
        end
    end

    // stage 1: numerator sign and magnitude
    logic [MW-1:0]  n1_num;
    logic [MW-1:0]  r1_mag;
    logic           r1_neg;
    logic           r1_zero;
    logic [DW-1:0]  r1_den;
    logic           r1_beh;
    logic [CRW-1:0] r1_cen;

    assign n1_num = ({{22{r0_hi[41]}}, r0_hi} << 22) + {22'b0, r0_lo};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg  <= n1_num[MW-1];
            r1_zero <= (n1_num == '0);
            r1_mag  <= n1_num[MW-1] ? -n1_num : n1_num;
            r1_den  <= r0_den;
            r1_beh  <= r0_beh;
            r1_cen  <= r0_cen;
        end
    end

    // stage 2: round half up as floor((2m + d) / 2d)
    logic [NW-1:0]  r2_n;
    logic [DW-1:0]  r2_d;
    logic           r2_neg;
    logic           r2_zero;
    logic           r2_beh;
    logic [CRW-1:0] r2_cen;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_n    <= {r1_mag, 1'b0} + NW'(r1_den);
            r2_d    <= {r1_den[DW-2:0], 1'b0};
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
            r2_beh  <= r1_beh;
            r2_cen  <= r1_cen;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [XW-1:0]  r_rem  [0:QB];
    logic [QB-1:0]  r_q    [0:QB];
    logic [DW-1:0]  r_d    [0:QB];
    logic           r_ovf  [0:QB];
    logic           r_neg  [0:QB];
    logic           r_zero [0:QB];
    logic           r_beh  [0:QB];
    logic [CRW-1:0] r_cen  [0:QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= XW'(r2_n);
            r_q[0]    <= '0;
            r_d[0]    <= r2_d;
            r_ovf[0]  <= XW'(r2_n) >= (XW'(r2_d) << QB);
            r_neg[0]  <= r2_neg;
            r_zero[0] <= r2_zero;
            r_beh[0]  <= r2_beh;
            r_cen[0]  <= r2_cen;
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_div
        localparam int B = QB - s;
        logic [XW-1:0] n_trial;
        logic          n_ge;
        logic [QB-1:0] n_q;

        assign n_trial = XW'(r_d[s-1]) << B;
        assign n_ge    = r_rem[s-1] >= n_trial;

        always_comb begin
            n_q    = r_q[s-1];
            n_q[B] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_ge ? r_rem[s-1] - n_trial : r_rem[s-1];
                r_q[s]    <= n_q;
                r_d[s]    <= r_d[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_beh[s]  <= r_beh[s-1];
                r_cen[s]  <= r_cen[s-1];
            end
        end
    end

    // offset from centre, saturated
    logic [QB:0]        n_qf;
    logic signed [20:0] n_off;
    logic signed [20:0] n_sum;
    logic signed [OW-1:0] n_p;

    assign n_qf  = r_ovf[QB] ? (QB+1)'(1) << QB : {1'b0, r_q[QB]};
    assign n_off = r_neg[QB] ? -$signed({2'b0, n_qf}) : $signed({2'b0, n_qf});
    assign n_sum = $signed({8'b0, r_cen[QB]}) + n_off;

    always_comb begin
        if (r_beh[QB]) begin
            if (r_zero[QB])     n_p = $signed({4'b0, r_cen[QB]});
            else if (r_neg[QB]) n_p = COORD_MIN;
            else                n_p = COORD_MAX;
        end else if (n_sum > 21'sd65535) begin
            n_p = COORD_MAX;
        end else if (n_sum < -21'sd65536) begin
            n_p = COORD_MIN;
        end else begin
            n_p = n_sum[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_p <= n_p;
    end

endmodule

### src/box_screen_bounds_projector.sv
// Box screen bounds projector.
// i_box takes one box (centre relative to the camera, half extents, Q15.8);
// o_rect returns its clamped screen rectangle and a behind-camera flag.
// Both channels move a request when valid and ready are high together.
// The eight corners go one per cycle while o_rect is not stalled through a
// shared rotate, multiply and divide pipeline; a new box is taken only as
// the last corner of the previous one is issued, and i_box.ready stays low
// after a request while the corners are issued. Each axis has its own
// 18-stage restoring divider.
// The configuration port writes one register per cycle with i_cfg_we;
// write only while no box is in flight.
// Synchronous reset (i_rst_n low) empties the pipeline, drops o_rect.valid
// and restores the identity matrix, scale 8192, centre 512/384, 1024x768.
// If o_rect is stalled the whole pipeline holds; one more box can be taken
// and waits in the pipeline until the result is taken.
module box_screen_bounds_projector import bsp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsp_box_if.sink       i_box,
    bsp_rect_if.source    o_rect,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [RW-1:0] i_cfg_data
);

    logic [RW-1:0]  r_rot [0:2];
    logic [PSW-1:0] r_scale;
    logic [CRW-1:0] r_cen_x;
    logic [CRW-1:0] r_cen_y;
    logic [CRW-1:0] r_width;
    logic [CRW-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= 48'd16384;
            r_rot[1] <= 48'd1073741824;
            r_rot[2] <= 48'd70368744177664;
            r_scale  <= 20'd8192;
            r_cen_x  <= 13'd512;
            r_cen_y  <= 13'd384;
            r_width  <= 13'd1024;
            r_height <= 13'd768;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT0:     r_rot[0] <= i_cfg_data;
                CFG_ROT1:     r_rot[1] <= i_cfg_data;
                CFG_ROT2:     r_rot[2] <= i_cfg_data;
                CFG_SCALE:    r_scale  <= i_cfg_data[PSW-1:0];
                CFG_CENTRE_X: r_cen_x  <= i_cfg_data[CRW-1:0];
                CFG_CENTRE_Y: r_cen_y  <= i_cfg_data[CRW-1:0];
                CFG_WIDTH:    r_width  <= i_cfg_data[CRW-1:0];
                CFG_HEIGHT:   r_height <= i_cfg_data[CRW-1:0];
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    logic n_adv;
    assign n_adv = ~r_out_valid | o_rect.ready;

    // box register and corner sequencer
    logic signed [23:0] r_ctr  [0:2];
    logic [22:0]        r_half [0:2];
    logic               r_busy;
    logic [2:0]         r_cnt;
    logic               n_issue;
    logic               n_take;

    assign n_issue     = r_busy & n_adv;
    assign i_box.ready = ~r_busy | (r_cnt == 3'd7 & n_adv);
    assign n_take      = i_box.valid & i_box.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (n_take) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (n_issue) begin
            r_cnt  <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take) begin
            r_ctr[0]  <= i_box.center_x;
            r_ctr[1]  <= i_box.center_y;
            r_ctr[2]  <= i_box.center_z;
            r_half[0] <= i_box.half_x;
            r_half[1] <= i_box.half_y;
            r_half[2] <= i_box.half_z;
        end
    end

    // stage A: corner
    logic signed [CW-1:0] r_a_c [0:2];
    logic                 r_a_v;
    logic                 r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (n_adv) begin
            r_a_v <= n_issue;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_corner
        always_ff @(posedge i_clk) begin
            if (n_adv) begin
                r_a_c[a] <= r_cnt[a] ? {r_ctr[a][23], r_ctr[a]} + {2'b0, r_half[a]}
                                     : {r_ctr[a][23], r_ctr[a]} - {2'b0, r_half[a]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) r_a_last <= (r_cnt == 3'd7);
    end

    // stage B: nine products
    logic signed [PW-1:0] r_b_p [0:2][0:2];
    logic                 r_b_v;
    logic                 r_b_last;

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            always_ff @(posedge i_clk) begin
                if (n_adv) r_b_p[r][j] <= $signed(r_rot[r][KW*j +: KW]) * r_a_c[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (n_adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) r_b_last <= r_a_last;
    end

    // stage C: rotated components
    logic signed [TW-1:0] r_c_t [0:2];
    logic                 r_c_v;
    logic                 r_c_last;

    for (genvar r = 0; r < 3; r++) begin : g_sum
        always_ff @(posedge i_clk) begin
            if (n_adv) begin
                r_c_t[r] <= TW'(r_b_p[r][0]) + TW'(r_b_p[r][1]) + TW'(r_b_p[r][2]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (n_adv) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) r_c_last <= r_b_last;
    end

    // projection per axis
    logic signed [OW-1:0] w_px;
    logic signed [OW-1:0] w_py;

    bsp_axis u_axis_x (
        .i_clk (i_clk),
        .i_en  (n_adv),
        .i_cfg ('{scale: r_scale, centre: r_cen_x}),
        .i_t   (r_c_t[0]),
        .i_tz  (r_c_t[2]),
        .o_p   (w_px)
    );

    bsp_axis u_axis_y (
        .i_clk (i_clk),
        .i_en  (n_adv),
        .i_cfg ('{scale: r_scale, centre: r_cen_y}),
        .i_t   (r_c_t[1]),
        .i_tz  (r_c_t[2]),
        .o_p   (w_py)
    );

    // flags ride alongside the axis pipeline
    logic r_dl_v    [0:AXIS_LAT-1];
    logic r_dl_last [0:AXIS_LAT-1];
    logic r_dl_beh  [0:AXIS_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_LAT; i++) r_dl_v[i] <= 1'b0;
        end else if (n_adv) begin
            r_dl_v[0] <= r_c_v;
            for (int i = 1; i < AXIS_LAT; i++) r_dl_v[i] <= r_dl_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_dl_last[0] <= r_c_last;
            r_dl_beh[0]  <= ~r_c_t[2][TW-1];
            for (int i = 1; i < AXIS_LAT; i++) begin
                r_dl_last[i] <= r_dl_last[i-1];
                r_dl_beh[i]  <= r_dl_beh[i-1];
            end
        end
    end

    // min / max over corners
    logic                 r_acc_empty;
    logic                 r_acc_beh;
    logic signed [OW-1:0] r_minx, r_maxx, r_miny, r_maxy;
    logic signed [OW-1:0] n_minx, n_maxx, n_miny, n_maxy;
    logic                 n_beh;
    logic                 n_corner;
    logic signed [OW-1:0] n_wlim, n_hlim;

    assign n_corner = r_dl_v[AXIS_LAT-1] & n_adv;
    assign n_minx = (r_acc_empty || w_px < r_minx) ? w_px : r_minx;
    assign n_maxx = (r_acc_empty || w_px > r_maxx) ? w_px : r_maxx;
    assign n_miny = (r_acc_empty || w_py < r_miny) ? w_py : r_miny;
    assign n_maxy = (r_acc_empty || w_py > r_maxy) ? w_py : r_maxy;
    assign n_beh  = (~r_acc_empty & r_acc_beh) | r_dl_beh[AXIS_LAT-1];
    assign n_wlim = $signed({4'b0, r_width}) - EDGE_MARGIN;
    assign n_hlim = $signed({4'b0, r_height}) - EDGE_MARGIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_empty <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (n_corner) r_acc_empty <= r_dl_last[AXIS_LAT-1];
            if (n_corner && r_dl_last[AXIS_LAT-1]) r_out_valid <= 1'b1;
            else if (o_rect.ready)                 r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_corner) begin
            r_minx    <= n_minx;
            r_maxx    <= n_maxx;
            r_miny    <= n_miny;
            r_maxy    <= n_maxy;
            r_acc_beh <= n_beh;
        end
    end

    logic signed [OW-1:0] r_left, r_right, r_bottom, r_top;
    logic                 r_behind;

    always_ff @(posedge i_clk) begin
        if (n_corner && r_dl_last[AXIS_LAT-1]) begin
            r_left   <= (n_minx < EDGE_MARGIN) ? EDGE_MARGIN : n_minx;
            r_right  <= (n_maxx > n_wlim) ? n_wlim : n_maxx;
            r_bottom <= (n_miny < EDGE_MARGIN) ? EDGE_MARGIN : n_miny;
            r_top    <= (n_maxy > n_hlim) ? n_hlim : n_maxy;
            r_behind <= n_beh;
        end
    end

    assign o_rect.valid         = r_out_valid;
    assign o_rect.left          = r_left;
    assign o_rect.right         = r_right;
    assign o_rect.bottom        = r_bottom;
    assign o_rect.top           = r_top;
    assign o_rect.behind_camera = r_behind;

endmodule

### src/bsp_checker.sv
module bsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [16:0] i_left,
    input logic signed [16:0] i_bottom
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_margin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left >= 17'sd2) && (i_bottom >= 17'sd2))
        else $error("lower edge below margin");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("box taken before its corners were issued");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind box_screen_bounds_projector bsp_checker u_bsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_box.valid),
    .i_in_ready  (i_box.ready),
    .i_out_valid (o_rect.valid),
    .i_out_ready (o_rect.ready),
    .i_left      (o_rect.left),
    .i_bottom    (o_rect.bottom)
);

### tb/tb_box_if.sv
`timescale 1ns / 100ps
// Channel interfaces used by the testbench come from src; this file only
// holds a small helper package for the corner predictor.
package tb_bsp_util;
    typedef struct {
        logic signed [23:0] cx, cy, cz;
        logic [22:0]        hx, hy, hz;
    } t_box;
    typedef struct {
        logic signed [16:0] left, right, bottom, top;
        logic               behind;
    } t_rect;
endpackage

### tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import bsp_pkg::*;
    import tb_bsp_util::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [RW-1:0] i_cfg_data = '0;

    bsp_box_if box_ch();
    bsp_rect_if rect_ch();

    box_screen_bounds_projector DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_box(box_ch.sink), .o_rect(rect_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // shadow registers
    logic [47:0] rot[3];
    logic [19:0] scale_q;
    logic [12:0] cen_x, cen_y, scr_w, scr_h;

    t_rect rect_q[$];
    int errors = 0;
    int idle_cycles = 0;

    initial begin
        box_ch.valid = 1'b0;
        box_ch.center_x = '0; box_ch.center_y = '0; box_ch.center_z = '0;
        box_ch.half_x = '0; box_ch.half_y = '0; box_ch.half_z = '0;
        rect_ch.ready = 1'b0;
    end

    function automatic longint coef_of(logic [47:0] row, int j);
        logic signed [15:0] k;
        k = row[16*j +: 16];
        return longint'(k);
    endfunction

    function automatic longint axis_pos(longint t, longint tz, longint cen);
        longint num, mag, den, q, v;
        num = t * longint'(scale_q);
        if (tz >= 0) begin
            if (num > 0) return 65535;
            if (num < 0) return -65536;
            v = cen;
        end else begin
            den = (-tz) * 16;
            mag = (num < 0) ? -num : num;
            // 2*mag fits: |t|<2^42, scale<2^20
            q = (2 * mag + den) / (2 * den);
            if (q > (longint'(1) << 40)) q = longint'(1) << 40;
            v = cen + ((num < 0) ? -q : q);
        end
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v;
    endfunction

    function automatic t_rect project_box(t_box b);
        t_rect r;
        longint c[3], t[3], px, py, mnx, mxx, mny, mxy;
        bit behind;
        behind = 0;
        mnx = 0; mxx = 0; mny = 0; mxy = 0;
        for (int k = 0; k < 8; k++) begin
            c[0] = k[0] ? longint'(b.cx) + longint'(b.hx) : longint'(b.cx) - longint'(b.hx);
            c[1] = k[1] ? longint'(b.cy) + longint'(b.hy) : longint'(b.cy) - longint'(b.hy);
            c[2] = k[2] ? longint'(b.cz) + longint'(b.hz) : longint'(b.cz) - longint'(b.hz);
            for (int a = 0; a < 3; a++)
                t[a] = coef_of(rot[a], 0) * c[0] + coef_of(rot[a], 1) * c[1]
                     + coef_of(rot[a], 2) * c[2];
            if (t[2] >= 0) behind = 1;
            px = axis_pos(t[0], t[2], longint'(cen_x));
            py = axis_pos(t[1], t[2], longint'(cen_y));
            if (k == 0 || px < mnx) mnx = px;
            if (k == 0 || px > mxx) mxx = px;
            if (k == 0 || py < mny) mny = py;
            if (k == 0 || py > mxy) mxy = py;
        end
        if (mnx < 2) mnx = 2;
        if (mxx > longint'(scr_w) - 2) mxx = longint'(scr_w) - 2;
        if (mny < 2) mny = 2;
        if (mxy > longint'(scr_h) - 2) mxy = longint'(scr_h) - 2;
        r.left = mnx[16:0]; r.right = mxx[16:0];
        r.bottom = mny[16:0]; r.top = mxy[16:0];
        r.behind = behind;
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_ROT0:     rot[0] = val;
            CFG_ROT1:     rot[1] = val;
            CFG_ROT2:     rot[2] = val;
            CFG_SCALE:    scale_q = val[19:0];
            CFG_CENTRE_X: cen_x = val[12:0];
            CFG_CENTRE_Y: cen_y = val[12:0];
            CFG_WIDTH:    scr_w = val[12:0];
            default:      scr_h = val[12:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        box_ch.valid <= 1'b0;
        while (rect_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // valid stays high into the next request when no gap is drawn
    task automatic send_box(t_box b);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        box_ch.valid <= 1'b1;
        box_ch.center_x <= b.cx; box_ch.center_y <= b.cy; box_ch.center_z <= b.cz;
        box_ch.half_x <= b.hx; box_ch.half_y <= b.hy; box_ch.half_z <= b.hz;
        @(posedge i_clk);
        while (!box_ch.ready) @(posedge i_clk);
        rect_q.push_back(project_box(b));
    endtask

    function automatic t_box mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
        t_box b;
        b.cx = 24'(cx); b.cy = 24'(cy); b.cz = 24'(cz);
        b.hx = 23'(hx); b.hy = 23'(hy); b.hz = 23'(hz);
        return b;
    endfunction

    // mostly boxes in front of the camera at moderate scale
    function automatic t_box rand_box();
        t_box b;
        if ($urandom_range(0, 4) == 0) begin
            b.cx = 24'($urandom); b.cy = 24'($urandom); b.cz = 24'($urandom);
            b.hx = 23'($urandom); b.hy = 23'($urandom); b.hz = 23'($urandom);
        end else begin
            b.cx = 24'($signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000);
            b.cy = 24'($signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000);
            b.cz = 24'(-$signed($urandom_range(32'h800, 32'h40000)));
            b.hx = 23'($urandom_range(0, 32'h3000));
            b.hy = 23'($urandom_range(0, 32'h3000));
            b.hz = 23'($urandom_range(0, 32'h600));
        end
        return b;
    endfunction

    function automatic logic [47:0] rand_rot_row(int axis);
        logic [47:0] r;
        r = 48'({$urandom, $urandom});
        if ($urandom_range(0, 2) != 0) begin
            r = '0;
            r[16*axis +: 16] = (axis == 2) ? 16'sd16384 : 16'($urandom_range(8000, 16384));
            r[16*((axis+1)%3) +: 16] = 16'($urandom_range(0, 4000)) - 16'd2000;
        end
        return r;
    endfunction

    task automatic test_reset_defaults();
        rot[0] = 48'd16384; rot[1] = 48'd1073741824; rot[2] = 48'd70368744177664;
        scale_q = 20'd8192; cen_x = 13'd512; cen_y = 13'd384;
        scr_w = 13'd1024; scr_h = 13'd768;
        send_box(mk_box(0, 0, -2560, 256, 256, 256));
        send_box(mk_box(1000, -1000, -25600, 512, 512, 0));
        wait_idle();
    endtask

    task automatic test_directed();
        // field extremes
        send_box(mk_box(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        send_box(mk_box(-8388608, -8388608, -8388608, 0, 0, 0));
        send_box(mk_box(-8388608, 8388607, -8388608, 8388607, 0, 8388607));
        // zero depth on some corners, zero numerator behind camera
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 0, -256, 0, 0, 256));
        send_box(mk_box(-2560, 2560, 2560, 100, 100, 100));
        // tiny depth, quotients without a remainder
        send_box(mk_box(1, -1, -1, 0, 0, 0));
        send_box(mk_box(3, -3, -6, 0, 0, 0));
        wait_idle();
        // zero scale and small screen
        write_reg(CFG_SCALE, 48'd0);
        write_reg(CFG_WIDTH, 48'd0);
        write_reg(CFG_HEIGHT, 48'd3);
        send_box(mk_box(5000, -5000, -2560, 256, 256, 256));
        send_box(mk_box(5000, -5000, 2560, 256, 256, 256));
        wait_idle();
        write_reg(CFG_SCALE, 48'hFFFFF);
        write_reg(CFG_CENTRE_X, 48'd8191);
        write_reg(CFG_CENTRE_Y, 48'd0);
        write_reg(CFG_WIDTH, 48'd8191);
        write_reg(CFG_HEIGHT, 48'd8191);
        write_reg(CFG_ROT0, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_ROT1, 48'h8000_8000_8000);
        write_reg(CFG_ROT2, 48'h7FFF_7FFF_7FFF);
        send_box(mk_box(8388607, -8388608, -8388608, 8388607, 8388607, 8388607));
        send_box(mk_box(-100, 100, -8388608, 10, 10, 10));
        send_box(mk_box(100, 100, 100, 0, 0, 0));
        wait_idle();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_ROT0, rand_rot_row(0));
            write_reg(CFG_ROT1, rand_rot_row(1));
            write_reg(CFG_ROT2, rand_rot_row(2));
            write_reg(CFG_SCALE, ($urandom_range(0, 5) == 0) ? 48'($urandom_range(0, 20'hFFFFF))
                                                              : 48'($urandom_range(1, 20000)));
            write_reg(CFG_CENTRE_X, 48'($urandom_range(0, 8191)));
            write_reg(CFG_CENTRE_Y, 48'($urandom_range(0, 8191)));
            write_reg(CFG_WIDTH, 48'($urandom_range(0, 8191)));
            write_reg(CFG_HEIGHT, 48'($urandom_range(0, 8191)));
            for (int n = 0; n < 100; n++) send_box(rand_box());
            wait_idle();
        end
    endtask

    // result checker and output stall
    always @(posedge i_clk) begin
        t_rect e;
        if (i_rst_n && rect_ch.valid && rect_ch.ready) begin
            if (rect_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected rect request");
            end else begin
                e = rect_q.pop_front();
                if (rect_ch.left !== e.left || rect_ch.right !== e.right ||
                    rect_ch.bottom !== e.bottom || rect_ch.top !== e.top ||
                    rect_ch.behind_camera !== e.behind) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                                 e.left, e.right, e.bottom, e.top, e.behind,
                                 rect_ch.left, rect_ch.right, rect_ch.bottom, rect_ch.top,
                                 rect_ch.behind_camera);
                end
            end
        end
    end

    initial begin : sink_stall
        int gap;
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                rect_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rect_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rect_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((box_ch.valid && box_ch.ready) || (rect_ch.valid && rect_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random();
        if (errors == 0 && rect_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

### box_screen_bounds_projector.f
src/bsp_pkg.sv
src/bsp_box_if.sv
src/bsp_rect_if.sv
src/bsp_axis.sv
src/box_screen_bounds_projector.sv
src/bsp_checker.sv
tb/tb_box_if.sv
tb/testbench.sv
